// File: hdl/assert_macros.svh
// Assertion helpers for the checker file rbms_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define RBMS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define RBMS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rbms_pkg.sv
package rbms_pkg;

    localparam int ROW_MAX     = 64;
    localparam int IDX_W       = $clog2(ROW_MAX);
    localparam int CNT_W       = IDX_W + 1;
    localparam int WEIGHT_W    = 16;
    localparam int SUM_W       = 22;
    localparam int ALPHA_W     = 15;
    localparam int DIV_STEPS   = SUM_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [SUM_W-1:0] ALPHA_MAX = SUM_W'(32767);

    typedef enum logic [1:0] {
        ST_FILL,
        ST_DIV,
        ST_READ,
        ST_SHOW
    } state_t;

endpackage

// File: hdl/rbms_div.sv
module rbms_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [rbms_pkg::SUM_W-1:0]        dividend,
    input  logic [rbms_pkg::CNT_W-1:0]        divisor,
    output logic                              done,
    output logic [rbms_pkg::SUM_W-1:0]        quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [rbms_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [rbms_pkg::CNT_W-1:0]        rem_reg, rem_next;
    logic [rbms_pkg::CNT_W-1:0]        dvs_reg, dvs_next;
    logic [rbms_pkg::SUM_W-1:0]        quo_reg, quo_next;
    logic [rbms_pkg::CNT_W:0]          trial;
    logic                              fits;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[rbms_pkg::SUM_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? rbms_pkg::CNT_W'(trial - {1'b0, dvs_reg})
                            : rbms_pkg::CNT_W'(trial);
            quo_next = {quo_reg[rbms_pkg::SUM_W-2:0], fits};
            if (step_reg == rbms_pkg::STEP_W'(rbms_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/row_binarize_with_mean_abs_scale.sv
// Row binarizer with mean-absolute scaling. Elements of one row (up to 64) are
// taken one per cycle into a local store while the absolute sum is built; a row
// ends on last_in_row or when the 64th element arrives. Input ready then drops,
// a bit-serial divider forms alpha = sum / count (saturated to 32767), and the
// row is played back in order, each item by a store read and then an output
// that may stall on m_ready; input ready returns after the row's last item is
// taken. With row_mask set on the closing element each weight becomes +alpha
// (weight >= 0) or -alpha; otherwise weights pass through unchanged.
module row_binarize_with_mean_abs_scale (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [rbms_pkg::WEIGHT_W-1:0]  s_weight,
    input  logic                                  s_row_mask,
    input  logic                                  s_last_in_row,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [rbms_pkg::WEIGHT_W-1:0]  m_value,
    output logic                                  m_last_of_row
);

    rbms_pkg::state_t                   state_reg, state_next;
    logic [rbms_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [rbms_pkg::SUM_W-1:0]         sum_reg, sum_next;
    logic                               mask_reg, mask_next;
    logic [rbms_pkg::ALPHA_W-1:0]       alpha_reg, alpha_next;
    logic [rbms_pkg::IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [rbms_pkg::WEIGHT_W-1:0]      rd_data_reg;
    logic [rbms_pkg::WEIGHT_W-1:0]      row_mem [rbms_pkg::ROW_MAX];

    logic                               in_fire, out_fire, row_end, is_last;
    logic [rbms_pkg::WEIGHT_W-1:0]      abs_w, pos_alpha, neg_alpha;
    logic                               div_done;
    logic [rbms_pkg::SUM_W-1:0]         div_quo;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign row_end  = s_last_in_row ||
                      (count_reg == rbms_pkg::CNT_W'(rbms_pkg::ROW_MAX - 1));
    assign is_last  = ({1'b0, rd_idx_reg} + 1'b1) == count_reg;
    assign abs_w    = s_weight[rbms_pkg::WEIGHT_W-1] ? (~s_weight + 1'b1) : s_weight;

    rbms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_fire && row_end),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rbms_pkg::ST_FILL: begin
                if (in_fire && row_end) state_next = rbms_pkg::ST_DIV;
            end
            rbms_pkg::ST_DIV: begin
                if (div_done) state_next = rbms_pkg::ST_READ;
            end
            rbms_pkg::ST_READ: begin
                state_next = rbms_pkg::ST_SHOW;
            end
            rbms_pkg::ST_SHOW: begin
                if (out_fire) state_next = is_last ? rbms_pkg::ST_FILL : rbms_pkg::ST_READ;
            end
            default: state_next = rbms_pkg::ST_FILL;
        endcase
    end

    always_comb begin
        count_next  = count_reg;
        sum_next    = sum_reg;
        mask_next   = mask_reg;
        alpha_next  = alpha_reg;
        rd_idx_next = rd_idx_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        unique case (state_reg)
            rbms_pkg::ST_FILL: begin
                s_ready = 1'b1;
                if (in_fire) begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + rbms_pkg::SUM_W'(abs_w);
                    mask_next  = s_row_mask;
                end
            end
            rbms_pkg::ST_DIV: begin
                if (div_done) begin
                    alpha_next  = (div_quo > rbms_pkg::ALPHA_MAX)
                                ? rbms_pkg::ALPHA_W'(rbms_pkg::ALPHA_MAX)
                                : div_quo[rbms_pkg::ALPHA_W-1:0];
                    sum_next    = '0;
                    rd_idx_next = '0;
                end
            end
            rbms_pkg::ST_READ: begin
            end
            rbms_pkg::ST_SHOW: begin
                m_valid = 1'b1;
                if (out_fire) begin
                    if (is_last) begin
                        count_next = '0;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rbms_pkg::ST_FILL;
            count_reg <= '0;
            sum_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        mask_reg   <= mask_next;
        alpha_reg  <= alpha_next;
        rd_idx_reg <= rd_idx_next;
    end

    always_ff @(posedge aclk) begin
        if (in_fire) row_mem[count_reg[rbms_pkg::IDX_W-1:0]] <= s_weight;
        rd_data_reg <= row_mem[rd_idx_reg];
    end

    assign pos_alpha     = {1'b0, alpha_reg};
    assign neg_alpha     = ~pos_alpha + 1'b1;
    assign m_value       = mask_reg ? (rd_data_reg[rbms_pkg::WEIGHT_W-1] ? neg_alpha : pos_alpha)
                                    : rd_data_reg;
    assign m_last_of_row = is_last;

endmodule

// File: hdl/rbms_checker.sv
`include "assert_macros.svh"

module rbms_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  s_last_in_row,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [rbms_pkg::WEIGHT_W-1:0]  m_value,
    input logic                                  m_last_of_row
);

    `RBMS_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_value) && $stable(m_last_of_row), "stalled output item changed")

    `RBMS_ASSERT_IMP(a_one_side, aclk, aresetn, s_ready, !m_valid, "input taken while output pending")

    `RBMS_ASSERT_NXT(a_row_close, aclk, aresetn, s_valid && s_ready && s_last_in_row, !s_ready && !m_valid, "row end did not start alpha computation")

    `RBMS_ASSERT_NXT(a_row_done, aclk, aresetn, m_valid && m_ready && m_last_of_row, s_ready && !m_valid, "block not ready after row playback")

endmodule

bind row_binarize_with_mean_abs_scale rbms_checker u_rbms_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_last_in_row (s_last_in_row),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_value       (m_value),
    .m_last_of_row (m_last_of_row)
);

// File: dv/tb.sv
module tb;

    typedef struct packed {
        logic [rbms_pkg::WEIGHT_W-1:0] value;
        logic                          last;
    } bin_result_t;

    typedef struct packed {
        logic [rbms_pkg::WEIGHT_W-1:0] weight;
        logic                          mask;
        logic                          last;
        logic                          typed;
        logic [rbms_pkg::WEIGHT_W-1:0] typed_value;
    } weight_stim_t;

    localparam int N_DIRECTED   = 20;
    localparam int RANDOM_ITEMS = 350;
    localparam int HOLD_AT      = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 300;

    localparam logic [rbms_pkg::WEIGHT_W-1:0] W_MAX  = 16'h7fff;
    localparam logic [rbms_pkg::WEIGHT_W-1:0] W_MIN  = 16'h8000;
    localparam logic [rbms_pkg::WEIGHT_W-1:0] W_NEG1 = 16'hffff;
    localparam logic [rbms_pkg::WEIGHT_W-1:0] W_ZERO = 16'h0000;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic signed [rbms_pkg::WEIGHT_W-1:0] s_weight = '0;
    logic                                 s_row_mask = 1'b0;
    logic                                 s_last_in_row = 1'b0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic signed [rbms_pkg::WEIGHT_W-1:0] m_value;
    logic                                 m_last_of_row;

    row_binarize_with_mean_abs_scale u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_weight      (s_weight),
        .s_row_mask    (s_row_mask),
        .s_last_in_row (s_last_in_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_last_of_row (m_last_of_row)
    );

    // row state mirrored from the block
    logic [rbms_pkg::WEIGHT_W-1:0] row_copy [rbms_pkg::ROW_MAX];
    logic [rbms_pkg::SUM_W-1:0]    row_abs_sum = '0;
    int                            row_fill = 0;

    bin_result_t   row_out_q [$];
    bin_result_t   expected_bin_q [$];
    weight_stim_t  directed_tab [N_DIRECTED];

    int  fail_count = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    bit  held_off = 1'b0;
    bit  calm = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stores one element; on row close, fills row_out_q with the played-back row
    task automatic binarize_predict(input logic [rbms_pkg::WEIGHT_W-1:0] w,
                                    input logic mask, input logic last);
        logic [16:0]                   mag;
        logic [rbms_pkg::SUM_W-1:0]    alpha;
        logic [rbms_pkg::WEIGHT_W-1:0] pos_a;
        logic [rbms_pkg::WEIGHT_W-1:0] neg_a;
        bin_result_t                   res;
        row_out_q.delete();
        row_copy[row_fill] = w;
        mag = w[rbms_pkg::WEIGHT_W-1] ? (17'h10000 - {1'b0, w}) : {1'b0, w};
        row_abs_sum = row_abs_sum + rbms_pkg::SUM_W'(mag);
        row_fill++;
        if (!last && row_fill < rbms_pkg::ROW_MAX) return;
        alpha = row_abs_sum / rbms_pkg::SUM_W'(row_fill);
        if (alpha > rbms_pkg::ALPHA_MAX) alpha = rbms_pkg::ALPHA_MAX;
        pos_a = alpha[rbms_pkg::WEIGHT_W-1:0];
        neg_a = 16'h0000 - pos_a;
        for (int i = 0; i < row_fill; i++) begin
            if (mask) res.value = row_copy[i][rbms_pkg::WEIGHT_W-1] ? neg_a : pos_a;
            else res.value = row_copy[i];
            res.last = (i == row_fill - 1);
            row_out_q.push_back(res);
        end
        row_abs_sum = '0;
        row_fill = 0;
    endtask

    task automatic send_weight(input weight_stim_t st);
        int g;
        s_valid       <= 1'b1;
        s_weight      <= st.weight;
        s_row_mask    <= st.mask;
        s_last_in_row <= st.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        binarize_predict(st.weight, st.mask, st.last);
        if (st.typed) expected_bin_q.push_back(bin_result_t'{st.typed_value, 1'b1});
        else foreach (row_out_q[i]) expected_bin_q.push_back(row_out_q[i]);
        items_sent++;
        g = calm ? 0 : idle_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic logic [rbms_pkg::WEIGHT_W-1:0] pick_weight(input int style);
        int r;
        case (style)
            0: return rbms_pkg::WEIGHT_W'($urandom());
            1: begin
                r = $urandom_range(0, 4);
                case (r)
                    0: return W_MAX;
                    1: return W_MIN;
                    2: return W_NEG1;
                    3: return W_ZERO;
                    default: return rbms_pkg::WEIGHT_W'($urandom());
                endcase
            end
            2: return rbms_pkg::WEIGHT_W'($signed($urandom_range(0, 64)) - 32);
            default: return W_MIN | rbms_pkg::WEIGHT_W'($urandom_range(0, 3));
        endcase
    endfunction

    // result side
    initial begin
        int g;
        bin_result_t exp_r;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                results_seen++;
                if (expected_bin_q.size() == 0) begin
                    $error("unexpected item: value=%0d last_of_row=%0b",
                           m_value, m_last_of_row);
                    fail_count++;
                end else begin
                    exp_r = expected_bin_q.pop_front();
                    if (m_value !== exp_r.value) begin
                        $error("value: expected %0d, got %0d",
                               $signed(exp_r.value), m_value);
                        fail_count++;
                    end
                    if (m_last_of_row !== exp_r.last) begin
                        $error("last_of_row: expected %0b, got %0b",
                               exp_r.last, m_last_of_row);
                        fail_count++;
                    end
                end
            end
            if (!held_off && results_seen >= HOLD_AT) begin
                held_off = 1'b1;
                g = HOLD_CYCLES;
            end else begin
                g = calm ? 0 : idle_len();
            end
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // input side
    initial begin
        weight_stim_t st;
        int kind;
        int row_len;
        int style;
        int rand_items;
        bit paused;

        directed_tab = '{
            // single-element rows: alpha equals |w|, saturated to 32767
            '{W_MAX,  1'b1, 1'b1, 1'b1, W_MAX},
            '{W_MIN,  1'b1, 1'b1, 1'b1, 16'h8001},
            '{W_ZERO, 1'b1, 1'b1, 1'b1, W_ZERO},
            '{W_MIN,  1'b0, 1'b1, 1'b1, W_MIN},
            '{W_MAX,  1'b0, 1'b1, 1'b1, W_MAX},
            '{W_NEG1, 1'b1, 1'b1, 1'b1, W_NEG1},
            '{16'h0001, 1'b1, 1'b1, 1'b1, 16'h0001},
            // saturated alpha over several elements
            '{W_MIN, 1'b0, 1'b0, 1'b0, W_ZERO},
            '{W_MIN, 1'b0, 1'b0, 1'b0, W_ZERO},
            '{W_MIN, 1'b1, 1'b1, 1'b0, W_ZERO},
            // mask is taken from the closing element only
            '{W_ZERO,   1'b1, 1'b0, 1'b0, W_ZERO},
            '{16'hfffb, 1'b1, 1'b0, 1'b0, W_ZERO},
            '{16'h0064, 1'b1, 1'b0, 1'b0, W_ZERO},
            '{W_MAX,    1'b0, 1'b1, 1'b0, W_ZERO},
            '{W_ZERO,   1'b0, 1'b0, 1'b0, W_ZERO},
            '{16'hfffb, 1'b0, 1'b0, 1'b0, W_ZERO},
            '{16'h0064, 1'b0, 1'b0, 1'b0, W_ZERO},
            '{W_MIN,    1'b1, 1'b1, 1'b0, W_ZERO},
            // zero weights binarize to +alpha
            '{W_ZERO, 1'b0, 1'b0, 1'b0, W_ZERO},
            '{W_NEG1, 1'b1, 1'b1, 1'b0, W_ZERO}
        };

        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        foreach (directed_tab[i]) send_weight(directed_tab[i]);

        rand_items = 0;
        paused = 1'b0;
        while (rand_items < RANDOM_ITEMS) begin
            kind  = $urandom_range(0, 99);
            style = $urandom_range(0, 3);
            calm  = ($urandom_range(0, 4) == 0);
            if (kind < 55) row_len = $urandom_range(1, 8);
            else if (kind < 80) row_len = $urandom_range(9, 32);
            else if (kind < 90) row_len = $urandom_range(33, 63);
            else if (kind < 95) row_len = rbms_pkg::ROW_MAX;
            else row_len = $urandom_range(rbms_pkg::ROW_MAX + 1, 100);
            for (int k = 0; k < row_len; k++) begin
                st.weight      = pick_weight(style);
                st.mask        = 1'($urandom_range(0, 1));
                st.typed       = 1'b0;
                st.typed_value = W_ZERO;
                if (k == row_len - 1) begin
                    // a full-length row may close on its own without last
                    st.last = (row_len == rbms_pkg::ROW_MAX) ? 1'($urandom_range(0, 1))
                                                             : 1'b1;
                end else begin
                    st.last = 1'b0;
                end
                send_weight(st);
                rand_items++;
            end
            if (!paused && rand_items >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                while (expected_bin_q.size() != 0) @(posedge aclk);
                @(posedge aclk);
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (expected_bin_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
